// File: hw/rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared constants, types and helpers for the sample-to-chunk mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_CHUNK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 64;

  localparam logic [3:0] DP_NOP = 4'd0;
  localparam logic [3:0] DP_ACCEPT = 4'd1;
  localparam logic [3:0] DP_SQ_FETCH = 4'd2;
  localparam logic [3:0] DP_SQ_CMP = 4'd3;
  localparam logic [3:0] DP_SQ_ZERO = 4'd4;
  localparam logic [3:0] DP_DIV_INIT = 4'd5;
  localparam logic [3:0] DP_DIV_STEP = 4'd6;
  localparam logic [3:0] DP_SQ_MULQ = 4'd7;
  localparam logic [3:0] DP_SQ_END = 4'd8;
  localparam logic [3:0] DP_CQ_FETCH = 4'd9;
  localparam logic [3:0] DP_CQ_LAST = 4'd10;
  localparam logic [3:0] DP_CQ_ACC = 4'd11;
  localparam logic [3:0] DP_PUBLISH = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } scm_ctl_t;

  typedef struct packed {
    logic brk;
    logic cs_zero;
    logic have_prev;
    logic out_busy;
  } scm_sts_t;

  function automatic logic [31:0] span32(input logic [31:0] hi, input logic [31:0] lo);
    return (hi > lo) ? (hi - lo) : 32'd0;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scm_ram.sv
// ----------------------------------------------------------------------------
// scm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scm_datapath.sv
// ----------------------------------------------------------------------------
// scm_datapath
// Table storage, shared multiplier, serial divider, accumulators and the
// output register of the sample-to-chunk mapper.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_datapath
  import scm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scm_ctl_t              ctl,
  output scm_sts_t                   sts,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic [1:0]            in_cmd,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                out_chunk,
  output logic [31:0]                out_first,
  output logic [1:0]                 out_status
);

  logic [5:0]  f_index;
  logic [31:0] f_run_first;
  logic [31:0] f_run_samples;
  logic [31:0] f_query_sample;
  logic [31:0] f_query_chunk;

  assign f_index        = in_data[5:0];
  assign f_run_first    = in_data[37:6];
  assign f_run_samples  = in_data[69:38];
  assign f_query_sample = in_data[101:70];
  assign f_query_chunk  = in_data[133:102];

  logic [31:0] rd_start;
  logic [31:0] rd_samples;
  logic        wr_en;
  logic        in_range;

  assign in_range = (32'(f_index) < 32'(TABLE_ENTRIES));
  assign wr_en = (ctl.op == DP_ACCEPT) && (in_cmd == CMD_LOAD) && in_range;

  scm_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_start_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(f_index)),
    .wr_data (f_run_first),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_start)
  );

  scm_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_samples_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(f_index)),
    .wr_data (f_run_samples),
    .rd_en   (ctl.rd_en),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_samples)
  );

  logic [31:0] key;
  logic [31:0] c1;
  logic [31:0] cs;
  logic [31:0] total;
  logic        sat;
  logic [31:0] ent_start;
  logic [31:0] ent_samples;
  logic [31:0] prev_start;
  logic [31:0] prev_samples;
  logic        have_prev;
  logic [63:0] prod;
  logic [32:0] div_r;
  logic [31:0] div_q;
  logic [31:0] res_chunk;
  logic [31:0] res_first;
  logic [1:0]  res_status;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_res;
  logic [31:0] c2_min;

  assign c2_min = (rd_start < key) ? rd_start : key;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (ctl.op)
      DP_SQ_FETCH: begin
        mul_a = span32(rd_start, c1);
        mul_b = cs;
      end
      DP_SQ_MULQ: begin
        mul_a = div_q;
        mul_b = cs;
      end
      DP_CQ_FETCH: begin
        mul_a = have_prev ? span32(c2_min, prev_start) : 32'd0;
        mul_b = have_prev ? prev_samples : 32'd0;
      end
      DP_CQ_LAST: begin
        mul_a = span32(key, prev_start);
        mul_b = prev_samples;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_res = 64'(mul_a) * 64'(mul_b);

  logic [64:0] walk_sum;
  logic [32:0] r_sh;
  logic [32:0] c_sum;
  logic [64:0] acc_sum;

  assign walk_sum = 65'(total) + 65'(prod);
  assign r_sh     = {div_r[31:0], div_q[31]};
  assign c_sum    = 33'(div_q) + 33'(c1);
  assign acc_sum  = 65'(total) + 65'(prod);

  assign sts.brk       = (65'(key) < walk_sum);
  assign sts.cs_zero   = (cs == 32'd0);
  assign sts.have_prev = have_prev;
  assign sts.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      DP_ACCEPT: begin
        key   <= (in_cmd == CMD_SAMPLE) ? f_query_sample : f_query_chunk;
        c1    <= 32'd1;
        cs    <= 32'd0;
        total <= 32'd0;
        sat   <= 1'b0;
        if (in_cmd == CMD_CHUNK) begin
          res_chunk <= f_query_chunk;
        end else begin
          res_chunk <= 32'd0;
        end
        res_first <= 32'd0;
        if ((in_cmd == CMD_LOAD) && !in_range) begin
          res_status <= ST_RANGE;
        end else begin
          res_status <= ST_OK;
        end
      end
      DP_SQ_FETCH: begin
        ent_start   <= rd_start;
        ent_samples <= rd_samples;
        prod        <= mul_res;
      end
      DP_SQ_CMP: begin
        if (!sts.brk) begin
          cs    <= ent_samples;
          c1    <= ent_start;
          total <= walk_sum[31:0];
        end
      end
      DP_SQ_ZERO: begin
        res_chunk  <= 32'd1;
        res_first  <= total;
        res_status <= ST_OK;
      end
      DP_DIV_INIT: begin
        div_r <= 33'd0;
        div_q <= key - total;
      end
      DP_DIV_STEP: begin
        if (r_sh >= 33'(cs)) begin
          div_r <= r_sh - 33'(cs);
          div_q <= {div_q[30:0], 1'b1};
        end else begin
          div_r <= r_sh;
          div_q <= {div_q[30:0], 1'b0};
        end
      end
      DP_SQ_MULQ: begin
        prod <= mul_res;
      end
      DP_SQ_END: begin
        res_chunk  <= c_sum[32] ? 32'hFFFF_FFFF : c_sum[31:0];
        res_status <= c_sum[32] ? ST_SAT : ST_OK;
        res_first  <= total + prod[31:0];
      end
      DP_CQ_FETCH: begin
        prod         <= mul_res;
        prev_start   <= rd_start;
        prev_samples <= rd_samples;
      end
      DP_CQ_LAST: begin
        prod <= mul_res;
      end
      DP_CQ_ACC: begin
        if (acc_sum > 65'h0_FFFF_FFFF) begin
          total      <= 32'hFFFF_FFFF;
          sat        <= 1'b1;
          res_first  <= 32'hFFFF_FFFF;
          res_status <= ST_SAT;
        end else begin
          total      <= acc_sum[31:0];
          res_first  <= acc_sum[31:0];
          res_status <= sat ? ST_SAT : ST_OK;
        end
      end
      DP_PUBLISH: begin
        out_chunk  <= res_chunk;
        out_first  <= res_first;
        out_status <= res_status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      if (ctl.op == DP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.op == DP_ACCEPT) begin
        have_prev <= 1'b0;
      end else if (ctl.op == DP_CQ_FETCH) begin
        have_prev <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl
// Sequencer of the sample-to-chunk mapper: accepts commands, walks the
// table, runs the divider and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl
  import scm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data,
  output scm_ctl_t        ctl,
  input  wire scm_sts_t   sts
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SQ_RD    = 4'd1;
  localparam logic [3:0] S_SQ_FETCH = 4'd2;
  localparam logic [3:0] S_SQ_CMP   = 4'd3;
  localparam logic [3:0] S_SQ_DIV0  = 4'd4;
  localparam logic [3:0] S_DIV      = 4'd5;
  localparam logic [3:0] S_MULQ     = 4'd6;
  localparam logic [3:0] S_SQ_END   = 4'd7;
  localparam logic [3:0] S_CQ_RD    = 4'd8;
  localparam logic [3:0] S_CQ_FETCH = 4'd9;
  localparam logic [3:0] S_CQ_ACC   = 4'd10;
  localparam logic [3:0] S_CQ_LAST  = 4'd11;
  localparam logic [3:0] S_CQ_LACC  = 4'd12;
  localparam logic [3:0] S_FIN      = 4'd13;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [4:0]       step;
  logic [4:0]       step_next;
  logic [6:0]       entry_count;
  logic [CNT_W-1:0] n_runs;

  assign n_runs    = (32'(entry_count) > 32'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                             : CNT_W'(entry_count);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    step_next   = step;
    ctl.op      = DP_NOP;
    ctl.rd_en   = 1'b0;
    ctl.rd_addr = idx[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op   = DP_ACCEPT;
          idx_next = '0;
          if (in_cmd == CMD_SAMPLE) begin
            state_next = S_SQ_RD;
          end else if (in_cmd == CMD_CHUNK) begin
            state_next = S_CQ_RD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SQ_RD: begin
        if (idx < n_runs) begin
          ctl.rd_en  = 1'b1;
          state_next = S_SQ_FETCH;
        end else begin
          state_next = S_SQ_DIV0;
        end
      end
      S_SQ_FETCH: begin
        ctl.op     = DP_SQ_FETCH;
        state_next = S_SQ_CMP;
      end
      S_SQ_CMP: begin
        ctl.op = DP_SQ_CMP;
        if (sts.brk) begin
          state_next = S_SQ_DIV0;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SQ_RD;
        end
      end
      S_SQ_DIV0: begin
        if (sts.cs_zero) begin
          ctl.op     = DP_SQ_ZERO;
          state_next = S_FIN;
        end else begin
          ctl.op     = DP_DIV_INIT;
          step_next  = 5'd0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.op    = DP_DIV_STEP;
        step_next = step + 5'd1;
        if (step == 5'd31) begin
          state_next = S_MULQ;
        end
      end
      S_MULQ: begin
        ctl.op     = DP_SQ_MULQ;
        state_next = S_SQ_END;
      end
      S_SQ_END: begin
        ctl.op     = DP_SQ_END;
        state_next = S_FIN;
      end
      S_CQ_RD: begin
        if (idx < n_runs) begin
          ctl.rd_en  = 1'b1;
          state_next = S_CQ_FETCH;
        end else if (sts.have_prev) begin
          state_next = S_CQ_LAST;
        end else begin
          state_next = S_FIN;
        end
      end
      S_CQ_FETCH: begin
        ctl.op     = DP_CQ_FETCH;
        state_next = S_CQ_ACC;
      end
      S_CQ_ACC: begin
        ctl.op     = DP_CQ_ACC;
        idx_next   = idx + 1'b1;
        state_next = S_CQ_RD;
      end
      S_CQ_LAST: begin
        ctl.op     = DP_CQ_LAST;
        state_next = S_CQ_LACC;
      end
      S_CQ_LACC: begin
        ctl.op     = DP_CQ_ACC;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.op     = DP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      step        <= 5'd0;
      entry_count <= 7'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      step  <= step_next;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
    end
  end

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && sts.out_busy) |=> (state == S_FIN))
    else $error("result published while output register busy");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_RD || state == S_CQ_RD) |-> (idx <= n_runs))
    else $error("table walk index beyond valid runs");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == 5'd31) |=> (state == S_MULQ))
    else $error("divider did not finish after 32 steps");

  a_rd_fetch: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en |=> (state == S_SQ_FETCH || state == S_CQ_FETCH))
    else $error("table read not followed by fetch");

endmodule

`default_nettype wire

// File: hw/rtl/sample_chunk_mapper.sv
// ----------------------------------------------------------------------------
// sample_chunk_mapper
// Sample-to-chunk table with load, sample-to-chunk and chunk-to-sample
// queries; one result per command.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                Payload
//   s_axis    in         s_axis_tvalid/tready     tdata fields, tuser command
//   m_axis    out        m_axis_tvalid/tready     tdata chunk/first, tuser status
//   cfg       in         cfg_valid/cfg_ready      entry_count
//
// A load or an unused command goes to the hand-off with no table walk.
// A sample query walks the table runs, then runs the 32-step serial divider,
// the final multiply and the hand-off, or skips the divider when it ends in a
// run of zero samples per chunk; a chunk query accumulates each valid run,
// then the last run, unless the table is empty. One command is in work at a
// time; a new command is taken only in the idle state.
// Reset is synchronous; the table needs no clearing pass.
// A stalled output holds the finished result while the next command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_chunk_mapper
  import scm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // entry_index, run_first_chunk, run_samples_per_chunk, query_sample,
  // query_chunk, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // chunk_number, chunk_first_sample
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                 m_axis_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [6:0]            cfg_data
);

  scm_ctl_t    ctl;
  scm_sts_t    sts;
  logic [31:0] out_chunk;
  logic [31:0] out_first;

  scm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts)
  );

  scm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_data    (s_axis_tdata),
    .in_cmd     (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_chunk  (out_chunk),
    .out_first  (out_first),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = {out_first, out_chunk};

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sample-to-chunk mapper. Table loads, sample
// queries and chunk queries are sent over the input stream. Each accepted
// transaction is predicted by a local model of the table. Each output
// transaction is compared with the oldest prediction. Phases change the
// entry count and the idle and stall rates of both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import scm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  idx;
    logic [31:0] first_chunk;
    logic [31:0] per_chunk;
    logic [31:0] sample;
    logic [31:0] chunk;
  } cmd_t;

  typedef struct packed {
    logic [31:0] chunk_no;
    logic [31:0] first_smp;
    logic [1:0]  status;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;

  cmd_t pending_cmds[$];
  lookup_t expected_lookups[$];
  logic [31:0] start_tbl[TABLE_ENTRIES];
  logic [31:0] samples_tbl[TABLE_ENTRIES];
  int unsigned run_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  logic [31:0] gen_chunk;

  sample_chunk_mapper uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic lookup_t map_command(input cmd_t c);
    lookup_t r;
    int unsigned n;
    logic [63:0] c1, c2, cs, total, range, q;
    logic sat;
    r = '0;
    n = (run_count > TABLE_ENTRIES) ? TABLE_ENTRIES : run_count;
    case (c.cmd)
      CMD_LOAD: begin
        start_tbl[c.idx] = c.first_chunk;
        samples_tbl[c.idx] = c.per_chunk;
      end
      CMD_SAMPLE: begin
        c1 = 64'd1;
        cs = 64'd0;
        total = 64'd0;
        for (int i = 0; i < n; i++) begin
          c2 = start_tbl[i];
          range = ((c2 > c1) ? c2 - c1 : 64'd0) * cs;
          if (c.sample < total + range) break;
          cs = samples_tbl[i];
          c1 = c2;
          total += range;
        end
        if (cs != 0) begin
          q = (c.sample - total) / cs;
          c2 = q + c1;
          if (c2 > 64'hFFFF_FFFF) begin
            c2 = 64'hFFFF_FFFF;
            r.status = ST_SAT;
          end
          r.chunk_no = c2[31:0];
          total = total + q * cs;
          r.first_smp = total[31:0];
        end else begin
          r.chunk_no = 32'd1;
          r.first_smp = total[31:0];
        end
      end
      CMD_CHUNK: begin
        r.chunk_no = c.chunk;
        total = 64'd0;
        sat = 1'b0;
        for (int i = 0; i < n; i++) begin
          c1 = start_tbl[i];
          if (c.chunk > c1) begin
            c2 = c.chunk;
            if (i + 1 < n && start_tbl[i + 1] < c2) c2 = start_tbl[i + 1];
            range = ((c2 > c1) ? c2 - c1 : 64'd0) * samples_tbl[i];
            if (range > 64'hFFFF_FFFF - total) begin
              total = 64'hFFFF_FFFF;
              sat = 1'b1;
            end else begin
              total += range;
            end
          end
        end
        r.first_smp = total[31:0];
        r.status = sat ? ST_SAT : ST_OK;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
  end

  logic s_taken = 1'b0;
  cmd_t cur;
  always @(posedge clk) begin
    s_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst && cfg_valid && cfg_ready) run_count = cfg_data;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      cur.cmd = s_axis_tuser;
      {cur.chunk, cur.sample, cur.per_chunk, cur.first_chunk, cur.idx} = s_axis_tdata[133:0];
      expected_lookups.push_back(map_command(cur));
    end
  end

  always @(negedge clk) begin
    cmd_t c;
    if (rst || (s_axis_tvalid && !s_taken)) begin
    end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      c = pending_cmds.pop_front();
      s_axis_tdata <= {2'b00, c.chunk, c.sample, c.per_chunk, c.first_chunk, c.idx};
      s_axis_tuser <= c.cmd;
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    lookup_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result %h/%h", $realtime, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = expected_lookups.pop_front();
        if (m_axis_tdata[31:0] !== e.chunk_no) begin
          $display("%0t: chunk_number exp %h got %h", $realtime, e.chunk_no,
                   m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.first_smp) begin
          $display("%0t: chunk_first_sample exp %h got %h", $realtime, e.first_smp,
                   m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser !== e.status) begin
          $display("%0t: status exp %h got %h", $realtime, e.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  task automatic push(input logic [1:0] cmd, input logic [5:0] idx, input logic [31:0] fc,
                      input logic [31:0] spc, input logic [31:0] qs, input logic [31:0] qc);
    cmd_t c;
    c.cmd = cmd;
    c.idx = idx;
    c.first_chunk = fc;
    c.per_chunk = spc;
    c.sample = qs;
    c.chunk = qc;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_count(input logic [6:0] value);
    drain();
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_per_chunk();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 32'd0;
    if (p < 15) return 32'hFFFF_FFFF;
    if (p < 20) return $urandom;
    return $urandom_range(1, 8);
  endfunction

  task automatic load_table(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) gen_chunk = $urandom;
      else if ($urandom_range(0, 9) == 0 && gen_chunk > 3) gen_chunk -= 2;
      else gen_chunk += $urandom_range(0, 6);
      push(CMD_LOAD, i, gen_chunk, rnd_per_chunk(), $urandom, $urandom);
    end
  endtask

  task automatic random_cmds(input int unsigned n);
    int unsigned p;
    logic [31:0] qs, qc;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      qs = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000);
      qc = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 500);
      if (qc == 0) qc = 1;
      if (p < 10)
        push(CMD_LOAD, $urandom_range(0, TABLE_ENTRIES - 1), $urandom_range(1, 400),
             rnd_per_chunk(), $urandom, $urandom);
      else if (p < 14) push(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (p < 57) push(CMD_SAMPLE, $urandom, $urandom, $urandom, qs, $urandom);
      else push(CMD_CHUNK, $urandom, $urandom, $urandom, $urandom, qc);
    end
  endtask

  task automatic run_phase(input logic [6:0] count, input int unsigned tbl_len,
                           input int unsigned n, input int unsigned sidle,
                           input int unsigned ridle);
    drain();
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    gen_chunk = $urandom_range(1, 3);
    load_table(tbl_len);
    write_count(count);
    random_cmds(n);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, unused command and field extremes.
    push(CMD_SAMPLE, 6'h00, 32'd0, 32'd0, 32'd0, 32'd1);
    push(CMD_SAMPLE, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(CMD_CHUNK, 6'h00, 32'd0, 32'd0, 32'd0, 32'd1);
    push(CMD_CHUNK, 6'h3F, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    push(2'd3, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      push(CMD_LOAD, i, i + 1, 32'd2, 32'd0, 32'd0);
    write_count(7'd64);
    push(CMD_SAMPLE, 0, 0, 0, 32'd0, 0);
    push(CMD_SAMPLE, 0, 0, 0, 32'd127, 0);
    push(CMD_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 0);
    push(CMD_CHUNK, 0, 0, 0, 0, 32'd40);
    push(CMD_CHUNK, 0, 0, 0, 0, 32'hFFFF_FFFF);
    // Saturating totals, a zero-size run and a decreasing first chunk.
    push(CMD_LOAD, 6'd0, 32'd1, 32'hFFFF_FFFF, 0, 0);
    push(CMD_LOAD, 6'd1, 32'hFFFF_FFFF, 32'd1, 0, 0);
    push(CMD_LOAD, 6'd2, 32'd5, 32'd0, 0, 0);
    write_count(7'd2);
    push(CMD_CHUNK, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push(CMD_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 0);
    write_count(7'd3);
    push(CMD_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 0);
    push(CMD_CHUNK, 0, 0, 0, 0, 32'd6);
    write_count(7'd127);
    push(CMD_SAMPLE, 0, 0, 0, 32'd50, 0);

    run_phase(7'd64, 64, 150, 0, 0);
    run_phase(7'd8, 8, 150, 88, 0);
    run_phase(7'd1, 1, 150, 0, 88);
    run_phase(7'd127, 64, 120, 26, 26);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 500;
    random_cmds(60);
    run_phase(7'd0, 0, 60, 26, 26);
    run_phase(7'd20, 20, 100, 0, 0);

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
